// ----- rtl/ptns_pkg.sv -----
// Shared types and constants for the PWM tone note sequencer.
// Used by the top level, the divider and the checker.
package ptns_pkg;

  // Default note table depth
  localparam int NOTE_DEPTH_DEF = 64;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 6;
  localparam int FREQ_W  = 16;
  localparam int DUR_W   = 16;
  localparam int CNT_W   = 7;
  localparam int ENTRY_W = FREQ_W + DUR_W;

  // Stream widths
  localparam int S_TDATA_W = 48;  // idx, freq, dur, count: 45 bits used
  localparam int S_TUSER_W = CMD_W;
  localparam int M_TDATA_W = 8;   // pin_level, busy_res: 2 bits used

  // Timer constants
  localparam logic [31:0]       TIMER_CLOCK_HZ = 32'd1041749;
  localparam logic [FREQ_W-1:0] REST_TOP       = 16'd1042;

  // Periods per note: floor(f * d / 1000) as (p * MS_RECIP_MUL) >> MS_RECIP_SHIFT,
  // exact for every product below the saturation point (under 2**26)
  localparam int                        MS_RECIP_IN_W    = 26;
  localparam int                        MS_RECIP_MUL_W   = 27;
  localparam int                        MS_RECIP_SHIFT   = 36;
  localparam logic [MS_RECIP_MUL_W-1:0] MS_RECIP_MUL     = 27'd68719477;
  localparam logic [31:0]               PERIODS_SAT_PROD = 32'd65536000;  // 65536 * 1000

  // Divider operand widths
  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2,
    CMD_MUTE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  // Divider handshake
  typedef struct packed {
    logic                 start;
    logic [DIV_N_W-1:0]   dividend;
    logic [DIV_D_W-1:0]   divisor;
  } div_req_t;

endpackage

// ----- rtl/pwm_tone_note_sequencer_unit.sv -----
// Flow: an item that loads no note puts its result in the output register in the
// cycle after the transfer; an item that loads a note waits on the table read and,
// for a tone, one pass of the 32-step divider, then waits in S_DONE for a free output.
// Throughput: one item in flight; a stalled result holds off the next transfer.
// Reset (async, active low) clears the timer, sequence and mute state; the note
// table is undefined until written.
module pwm_tone_note_sequencer_unit #(
  parameter int NOTE_DEPTH = ptns_pkg::NOTE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [5:0] entry_index, [21:6] note_frequency, [37:22] note_duration_ms,
  // [44:38] note_count, [47:45] zero
  input  logic [ptns_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [ptns_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] pin_level, [1] busy_res, [7:2] zero
  output logic [ptns_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import ptns_pkg::*;

  localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

  function automatic logic [15:0] sat16(input logic [DIV_N_W-1:0] v);
    return (|v[DIV_N_W-1:16]) ? 16'hFFFF : v[15:0];
  endfunction

  // Input fields
  cmd_e              in_cmd;
  logic [IDX_W-1:0]  in_idx;
  logic [FREQ_W-1:0] in_freq;
  logic [DUR_W-1:0]  in_dur;
  logic [CNT_W-1:0]  in_cnt;

  assign in_cmd  = cmd_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[5:0];
  assign in_freq = s_axis_tdata[21:6];
  assign in_dur  = s_axis_tdata[37:22];
  assign in_cnt  = s_axis_tdata[44:38];

  state_e            state_q, state_d;
  logic [15:0]       tick_q, tick_d;
  logic [15:0]       top_q, top_d;
  logic [15:0]       duty_q, duty_d;
  logic [15:0]       left_q, left_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic              tone_q, tone_d;
  logic              playing_q, playing_d;
  logic              muted_q, muted_d;
  logic [31:0]       prod_q, prod_d;
  logic              out_vld_q, out_vld_d;
  logic              out_pin_q, out_pin_d;
  logic              out_busy_q, out_busy_d;

  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  logic              load_req;

  // Note table
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [AW+IDX_W:0]  idx_ext;
  logic [AW+CNT_W:0]  pos_ext;
  logic [FREQ_W-1:0]  rd_freq;
  logic [DUR_W-1:0]   rd_dur;

  // Divider
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_N_W-1:0] div_quo;
  logic [15:0]        div_sat;

  // Periods per note
  logic [MS_RECIP_IN_W+MS_RECIP_MUL_W-1:0] recip_prod;
  logic [15:0]                             left_sat;

  assign idx_ext   = (AW + IDX_W + 1)'(in_idx);
  assign pos_ext   = (AW + CNT_W + 1)'(pos_d);
  assign ram_waddr = idx_ext[AW-1:0];
  assign ram_raddr = pos_ext[AW-1:0];
  assign rd_freq   = ram_rdata[ENTRY_W-1:DUR_W];
  assign rd_dur    = ram_rdata[DUR_W-1:0];
  assign div_sat   = sat16(div_quo);

  assign recip_prod = prod_q[MS_RECIP_IN_W-1:0] * MS_RECIP_MUL;
  assign left_sat   = (prod_q >= PERIODS_SAT_PROD) ? 16'hFFFF
                                                   : recip_prod[MS_RECIP_SHIFT +: 16];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  ptns_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NOTE_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({in_freq, in_dur}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ptns_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    top_d     = top_q;
    duty_d    = duty_q;
    left_d    = left_q;
    pos_d     = pos_q;
    total_d   = total_q;
    tone_d    = tone_q;
    playing_d = playing_q;
    muted_d   = muted_q;
    prod_d    = prod_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    load_req  = 1'b0;
    out_load  = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = TIMER_CLOCK_HZ;
    div_req.divisor  = rd_freq;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            CMD_TICK: begin
              if (playing_q) begin
                if (tick_q >= top_q) begin
                  tick_d = '0;
                  if (left_q != '0) begin
                    left_d = 16'(left_q - 1'b1);
                  end else begin
                    pos_d = CNT_W'(pos_q + 1'b1);
                    if (pos_d < total_q) begin
                      load_req = 1'b1;
                    end else begin
                      playing_d = 1'b0;
                      tone_d    = 1'b0;
                    end
                  end
                end else begin
                  tick_d = 16'(tick_q + 1'b1);
                end
              end
            end
            CMD_WRITE: begin
              ram_we = 32'(in_idx) < NOTE_DEPTH;
            end
            CMD_START: begin
              total_d = (32'(in_cnt) > NOTE_DEPTH) ? CNT_W'(NOTE_DEPTH) : in_cnt;
              pos_d   = '0;
              if (in_cnt == '0) begin
                playing_d = 1'b0;
                tone_d    = 1'b0;
                tick_d    = '0;
              end else begin
                playing_d = 1'b1;
                load_req  = 1'b1;
              end
            end
            CMD_MUTE: begin
              muted_d = !muted_q;
            end
            default: ;
          endcase
          if (load_req) begin
            ram_re  = 1'b1;
            state_d = S_FETCH;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      S_FETCH: begin
        tick_d = '0;
        prod_d = rd_freq * rd_dur;
        if (rd_freq == '0) begin
          top_d   = REST_TOP;
          duty_d  = '0;
          left_d  = rd_dur;
          tone_d  = 1'b0;
          state_d = S_DONE;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          top_d   = div_sat;
          duty_d  = {1'b0, div_sat[15:1]};
          left_d  = left_sat;
          tone_d  = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold the finished note until the output register frees up
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_pin_d  = out_pin_q;
    out_busy_d = out_busy_q;
    if (out_load) begin
      out_vld_d  = 1'b1;
      out_pin_d  = playing_d && tone_d && !muted_d && (tick_d < duty_d);
      out_busy_d = playing_d;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tick_q    <= '0;
      top_q     <= '0;
      duty_q    <= '0;
      left_q    <= '0;
      pos_q     <= '0;
      total_q   <= '0;
      tone_q    <= 1'b0;
      playing_q <= 1'b0;
      muted_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tick_q    <= tick_d;
      top_q     <= top_d;
      duty_q    <= duty_d;
      left_q    <= left_d;
      pos_q     <= pos_d;
      total_q   <= total_d;
      tone_q    <= tone_d;
      playing_q <= playing_d;
      muted_q   <= muted_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    out_pin_q  <= out_pin_d;
    out_busy_q <= out_busy_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(M_TDATA_W - 2){1'b0}}, out_busy_q, out_pin_q};

endmodule

// ----- rtl/ptns_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ptns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ptns_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ptns_pkg for operand widths and the request struct.
module ptns_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ptns_pkg::div_req_t       req_i,
  output logic                     done_o,
  output logic [ptns_pkg::DIV_N_W-1:0] quotient_o
);
  import ptns_pkg::*;

  localparam int CW = $clog2(DIV_N_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [DIV_N_W-1:0] quo_q, quo_d;
  logic [DIV_D_W-1:0] rem_q, rem_d;
  logic [DIV_D_W-1:0] dvs_q, dvs_d;
  logic [DIV_D_W:0]   trial;
  logic               fits;

  assign trial = {rem_q, quo_q[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when the divisor fits
      rem_d = fits ? DIV_D_W'(trial - {1'b0, dvs_q}) : trial[DIV_D_W-1:0];
      quo_d = {quo_q[DIV_N_W-2:0], fits};
      cnt_d = CW'(cnt_q + 1'b1);
      if (cnt_q == CW'(DIV_N_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/ptns_checker.sv -----
// Port-level checks for the PWM tone note sequencer, bound to the top level.
// Depends on ptns_pkg for stream widths.
module ptns_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ptns_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import ptns_pkg::*;

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q, pend_d;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // count items taken whose result has not been transferred yet
  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer && pend_q != 2'd3) begin
      pend_d = 2'(pend_q + 1'b1);
    end else if (out_xfer && !in_xfer && pend_q != 2'd0) begin
      pend_d = 2'(pend_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while a result is stalled");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result shown with no item outstanding");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> pend_q == 2'd0 || out_xfer)
    else $error("second item taken before the first result left");

endmodule

bind pwm_tone_note_sequencer_unit ptns_checker u_ptns_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
